### hw/rtl/ptrp_pkg.sv
package ptrp_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h80;

    localparam int NUM_IDS = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_PCSCF_IPV4 = 2'd0;
    localparam logic [1:0] REG_PCSCF_IPV6 = 2'd1;
    localparam logic [1:0] REG_DNS_IPV4   = 2'd2;
    localparam logic [1:0] REG_DNS_IPV6   = 2'd3;

    localparam logic [15:0] RST_PCSCF_IPV4 = 16'd12;
    localparam logic [15:0] RST_PCSCF_IPV6 = 16'd1;
    localparam logic [15:0] RST_DNS_IPV4   = 16'd13;
    localparam logic [15:0] RST_DNS_IPV6   = 16'd3;

    localparam logic [2:0] MATCH_NONE = 3'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_HDR = 2'd1;
    localparam logic [1:0] STATUS_LENGTH  = 2'd2;

    localparam logic [8:0] COUNT_MAX = 9'd256;
    localparam logic [8:0] MSG_MAX   = 9'd255;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       msg_last;
    } t_in_item;

    typedef struct packed {
        logic       is_status;
        logic [1:0] attr_kind;
        logic [7:0] attr_byte;
        logic       attr_end;
        logic [1:0] status_code;
        logic       result_last;
    } t_out_item;

endpackage

### hw/rtl/pco_tlv_response_parser.sv
// A result is written into the result queue when its input item is accepted. One
// byte is taken per cycle while the queue has room for two results. A message's final
// byte can cause an attribute and a status item; the four-entry queue absorbs that.
// Reset (synchronous, active low) returns the parser to expect a header byte, empties
// the result queue and loads the protocol id registers with 12, 1, 13 and 3.
module pco_tlv_response_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ptrp_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output ptrp_pkg::t_out_item o_out_item,
    input  logic                i_out_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ptrp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_LENGTH,
        PH_VALUE
    } t_phase;

    localparam int QDEPTH = 4;

    logic [15:0] r_ids [NUM_IDS];

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type_hi, n_type_hi;
    logic [7:0]  r_remaining, n_remaining;
    logic [2:0]  r_match, n_match;
    logic        r_header_bad, n_header_bad;
    logic [8:0]  r_count, n_count;

    t_out_item   r_queue [QDEPTH];
    logic [1:0]  r_wr_ptr, r_rd_ptr;
    logic [2:0]  r_fill;

    logic        in_accept, out_accept, cfg_write;
    logic        attr_emit, status_emit;
    logic [15:0] cur_type;
    logic [1:0]  status_code;
    t_out_item   attr_res, status_res, res0;
    logic [1:0]  push_cnt;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = o_out_valid && !i_out_stall;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = {16'd0, r_ids[paddr[3:2]]};

    // The queue must have room for two results before a byte is taken.
    assign o_in_stall  = (r_fill > 3'(QDEPTH - 2));
    assign o_out_valid = (r_fill != 3'd0);
    assign o_out_item  = r_queue[r_rd_ptr];

    assign cur_type = {r_type_hi, i_in_item.msg_byte};

    always_comb begin
        n_phase      = r_phase;
        n_type_hi    = r_type_hi;
        n_remaining  = r_remaining;
        n_match      = r_match;
        n_header_bad = r_header_bad;
        n_count      = (r_count < COUNT_MAX) ? r_count + 9'd1 : r_count;
        attr_emit    = 1'b0;
        case (r_phase)
            PH_HEADER: begin
                n_header_bad = (i_in_item.msg_byte != HEADER_BYTE);
                n_phase      = PH_TYPE_HI;
            end
            PH_TYPE_HI: begin
                n_type_hi = i_in_item.msg_byte;
                n_phase   = PH_TYPE_LO;
            end
            PH_TYPE_LO: begin
                // Lowest kind wins when several ids are equal.
                if (cur_type == r_ids[REG_PCSCF_IPV4]) begin
                    n_match = {1'b0, REG_PCSCF_IPV4};
                end else if (cur_type == r_ids[REG_PCSCF_IPV6]) begin
                    n_match = {1'b0, REG_PCSCF_IPV6};
                end else if (cur_type == r_ids[REG_DNS_IPV4]) begin
                    n_match = {1'b0, REG_DNS_IPV4};
                end else if (cur_type == r_ids[REG_DNS_IPV6]) begin
                    n_match = {1'b0, REG_DNS_IPV6};
                end else begin
                    n_match = MATCH_NONE;
                end
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_remaining = i_in_item.msg_byte;
                n_phase     = (i_in_item.msg_byte == 8'd0) ? PH_TYPE_HI : PH_VALUE;
            end
            PH_VALUE: begin
                attr_emit   = (r_match != MATCH_NONE) && !r_header_bad;
                n_remaining = r_remaining - 8'd1;
                if (r_remaining == 8'd1) begin
                    n_phase = PH_TYPE_HI;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        status_emit = i_in_item.msg_last;
        if (n_header_bad) begin
            status_code = STATUS_BAD_HDR;
        end else if (n_count > MSG_MAX || n_phase != PH_TYPE_HI) begin
            status_code = STATUS_LENGTH;
        end else begin
            status_code = STATUS_OK;
        end

        attr_res.is_status   = 1'b0;
        attr_res.attr_kind   = r_match[1:0];
        attr_res.attr_byte   = i_in_item.msg_byte;
        attr_res.attr_end    = (r_remaining == 8'd1);
        attr_res.status_code = STATUS_OK;
        attr_res.result_last = !status_emit;

        status_res.is_status   = 1'b1;
        status_res.attr_kind   = 2'd0;
        status_res.attr_byte   = 8'd0;
        status_res.attr_end    = 1'b0;
        status_res.status_code = status_code;
        status_res.result_last = 1'b1;

        res0     = attr_emit ? attr_res : status_res;
        push_cnt = {1'b0, attr_emit} + {1'b0, status_emit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids[REG_PCSCF_IPV4] <= RST_PCSCF_IPV4;
            r_ids[REG_PCSCF_IPV6] <= RST_PCSCF_IPV6;
            r_ids[REG_DNS_IPV4]   <= RST_DNS_IPV4;
            r_ids[REG_DNS_IPV6]   <= RST_DNS_IPV6;
        end else if (cfg_write) begin
            r_ids[paddr[3:2]] <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_type_hi    <= 8'd0;
            r_remaining  <= 8'd0;
            r_match      <= MATCH_NONE;
            r_header_bad <= 1'b0;
            r_count      <= 9'd0;
        end else if (in_accept) begin
            if (i_in_item.msg_last) begin
                r_phase      <= PH_HEADER;
                r_type_hi    <= 8'd0;
                r_remaining  <= 8'd0;
                r_match      <= MATCH_NONE;
                r_header_bad <= 1'b0;
                r_count      <= 9'd0;
            end else begin
                r_phase      <= n_phase;
                r_type_hi    <= n_type_hi;
                r_remaining  <= n_remaining;
                r_match      <= n_match;
                r_header_bad <= n_header_bad;
                r_count      <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_accept && push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + 2'd1] <= status_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_fill   <= 3'd0;
        end else begin
            if (in_accept) begin
                r_wr_ptr <= r_wr_ptr + push_cnt;
            end
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_fill <= r_fill + (in_accept ? {1'b0, push_cnt} : 3'd0)
                      - {2'b00, out_accept};
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'(QDEPTH))
        else $error("result queue overflow");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_status |-> o_out_item.result_last)
        else $error("status item not marked as last result");

    a_attr_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.is_status |-> o_out_item.status_code == STATUS_OK)
        else $error("attribute item carries a status code");

    a_msg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_in_item.msg_last |=> r_phase == PH_HEADER && r_count == 9'd0)
        else $error("parser did not restart after message end");

endmodule

### test/tb_pco_tlv_response_parser.sv
module tb_pco_tlv_response_parser;
    import ptrp_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 155;
    localparam int PRESSURE_PHASE = 5;
    localparam int HOLD_CYCLES = 200;

    typedef enum logic [2:0] {
        FLD_HEADER,
        FLD_TYPE_HI,
        FLD_TYPE_LO,
        FLD_LENGTH,
        FLD_VALUE
    } t_field;

    typedef struct {
        logic [7:0] val;
        logic       last;
        logic       typed;
        t_out_item  want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_item    i_in_item;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        i_out_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pco_tlv_response_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .i_out_stall(i_out_stall),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // Copy of the protocol id registers and of the parser state.
    logic [15:0] proto_id [NUM_IDS];
    t_field      p_field;
    logic [15:0] p_type;
    logic [7:0]  p_left;
    logic [2:0]  p_match;
    logic        p_hdr_bad;
    logic [8:0]  p_count;

    t_out_item awaited[$];
    int        errors = 0;
    int        sent_count = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        phase_no = -1;

    function automatic t_out_item status_item(input logic [1:0] code);
        t_out_item r;
        r = '0;
        r.is_status = 1'b1;
        r.status_code = code;
        r.result_last = 1'b1;
        return r;
    endfunction

    // A kind equals the index of the register whose id matched.
    function automatic t_out_item attr_item(input logic [1:0] kind, input logic [7:0] val,
                                            input logic fin, input logic last);
        t_out_item r;
        r = '0;
        r.attr_kind = kind;
        r.attr_byte = val;
        r.attr_end = fin;
        r.result_last = last;
        return r;
    endfunction

    function automatic void clear_parse_state();
        p_field = FLD_HEADER;
        p_type = '0;
        p_left = '0;
        p_match = MATCH_NONE;
        p_hdr_bad = 1'b0;
        p_count = '0;
    endfunction

    function automatic void parse_pco_byte(input t_in_item it, ref t_out_item res[$]);
        int         k;
        logic [1:0] code;
        res.delete();
        if (p_count < COUNT_MAX) begin
            p_count = p_count + 9'd1;
        end
        case (p_field)
            FLD_HEADER: begin
                p_hdr_bad = (it.msg_byte != HEADER_BYTE);
                p_field = FLD_TYPE_HI;
            end
            FLD_TYPE_HI: begin
                p_type = {it.msg_byte, 8'h00};
                p_field = FLD_TYPE_LO;
            end
            FLD_TYPE_LO: begin
                p_type[7:0] = it.msg_byte;
                // Walk downward so that the lowest matching kind is kept.
                p_match = MATCH_NONE;
                for (k = NUM_IDS - 1; k >= 0; k--) begin
                    if (p_type == proto_id[k]) p_match = 3'(k);
                end
                p_field = FLD_LENGTH;
            end
            FLD_LENGTH: begin
                p_left = it.msg_byte;
                p_field = (it.msg_byte == 8'd0) ? FLD_TYPE_HI : FLD_VALUE;
            end
            default: begin
                if (p_match != MATCH_NONE && !p_hdr_bad) begin
                    res.push_back(attr_item(p_match[1:0], it.msg_byte, p_left == 8'd1, 1'b0));
                end
                p_left = p_left - 8'd1;
                if (p_left == 8'd0) p_field = FLD_TYPE_HI;
            end
        endcase
        if (it.msg_last) begin
            if (p_hdr_bad) begin
                code = STATUS_BAD_HDR;
            end else if (p_count > MSG_MAX || p_field != FLD_TYPE_HI) begin
                code = STATUS_LENGTH;
            end else begin
                code = STATUS_OK;
            end
            res.push_back(status_item(code));
            clear_parse_state();
        end
        if (res.size() > 0) res[res.size() - 1].result_last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_byte(input logic [7:0] val, input logic last, input logic typed,
                             input t_out_item want);
        t_in_item  it;
        t_out_item res[$];
        it.msg_byte = val;
        it.msg_last = last;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
        parse_pco_byte(it, res);
        if (typed) begin
            awaited.push_back(want);
        end else begin
            foreach (res[k]) awaited.push_back(res[k]);
        end
    endtask

    // Builds one message and sends it. A fixed length gives a well-formed message
    // with one matching TLV of that length; otherwise the shape is random.
    task automatic send_message(input int fixed_len);
        logic [7:0]  msg[$];
        logic [15:0] tlv_type;
        int          shape;
        int          n_tlv;
        int          len;
        int          cut;
        shape = $urandom_range(0, 99);
        if (fixed_len >= 0) begin
            tlv_type = proto_id[$urandom_range(0, NUM_IDS - 1)];
            msg = '{HEADER_BYTE, tlv_type[15:8], tlv_type[7:0], 8'(fixed_len)};
            repeat (fixed_len) msg.push_back(8'($urandom));
        end else if (shape < 6) begin
            repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom));
        end else begin
            msg.push_back((shape < 12) ? 8'($urandom) : HEADER_BYTE);
            n_tlv = $urandom_range(0, 4);
            repeat (n_tlv) begin
                if ($urandom_range(0, 3) != 0) begin
                    tlv_type = proto_id[$urandom_range(0, NUM_IDS - 1)];
                end else begin
                    tlv_type = 16'($urandom);
                end
                if ($urandom_range(0, 9) == 0) begin
                    len = 0;
                end else if ($urandom_range(0, 19) == 0) begin
                    len = $urandom_range(9, 40);
                end else begin
                    len = $urandom_range(1, 8);
                end
                msg.push_back(tlv_type[15:8]);
                msg.push_back(tlv_type[7:0]);
                msg.push_back(8'(len));
                repeat (len) msg.push_back(8'($urandom));
            end
            // Some messages are cut short at a random byte, which may fall inside a TLV header or value.
            if (shape >= 88 && msg.size() > 1) begin
                cut = $urandom_range(1, msg.size() - 1);
                while (msg.size() > cut) void'(msg.pop_back());
            end
        end
        foreach (msg[k]) send_byte(msg[k], k == msg.size() - 1, 1'b0, '0);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0000, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (wr) begin
            proto_id[idx] = val;
        end else if (prdata !== {16'h0000, proto_id[idx]}) begin
            report_mismatch("register readback", prdata[15:0], proto_id[idx]);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_results(input int pause);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (pause) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : out_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited.size() == 0) begin
                report_mismatch("item with none expected", 16'(o_out_item), 16'h0000);
            end else begin
                want = awaited.pop_front();
                if (o_out_item.is_status !== want.is_status)
                    report_mismatch("is_status", 16'(o_out_item.is_status),
                                    16'(want.is_status));
                if (o_out_item.attr_kind !== want.attr_kind)
                    report_mismatch("attr_kind", 16'(o_out_item.attr_kind),
                                    16'(want.attr_kind));
                if (o_out_item.attr_byte !== want.attr_byte)
                    report_mismatch("attr_byte", 16'(o_out_item.attr_byte),
                                    16'(want.attr_byte));
                if (o_out_item.attr_end !== want.attr_end)
                    report_mismatch("attr_end", 16'(o_out_item.attr_end),
                                    16'(want.attr_end));
                if (o_out_item.status_code !== want.status_code)
                    report_mismatch("status_code", 16'(o_out_item.status_code),
                                    16'(want.status_code));
                if (o_out_item.result_last !== want.result_last)
                    report_mismatch("result_last", 16'(o_out_item.result_last),
                                    16'(want.result_last));
            end
        end
    end

    // The output side stalls at random, and once holds off long enough that the
    // parser fills up and stalls its input.
    initial begin : rx_side
        int   hold_left;
        logic held;
        hold_left = 0;
        held = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && phase_no == PRESSURE_PHASE) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        t_dir_row    steps [21];
        logic [15:0] ids [NUM_IDS];
        int          start;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        proto_id[REG_PCSCF_IPV4] = RST_PCSCF_IPV4;
        proto_id[REG_PCSCF_IPV6] = RST_PCSCF_IPV6;
        proto_id[REG_DNS_IPV4] = RST_DNS_IPV4;
        proto_id[REG_DNS_IPV6] = RST_DNS_IPV6;
        clear_parse_state();

        // Reset ids are 12, 1, 13 and 3; the types below are chosen against them.
        steps = '{
            '{HEADER_BYTE, 1'b1, 1'b1, status_item(STATUS_OK)},
            '{8'h00, 1'b1, 1'b1, status_item(STATUS_BAD_HDR)},
            '{HEADER_BYTE, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h0C, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, attr_item(REG_PCSCF_IPV4, 8'hFF, 1'b0, 1'b1)},
            '{8'h00, 1'b1, 1'b0, '0},
            '{HEADER_BYTE, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h01, 1'b1, 1'b1, status_item(STATUS_LENGTH)},
            '{HEADER_BYTE, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h03, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h5A, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h0D, 1'b0, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h00, 1'b1, 1'b1, status_item(STATUS_BAD_HDR)}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 13;
        rx_idle_pct = 80;
        foreach (steps[k]) send_byte(steps[k].val, steps[k].last, steps[k].typed, steps[k].want);

        for (int ph = 0; ph <= PRESSURE_PHASE; ph++) begin
            drain_results(4);
            if (ph < 2) begin
                tx_idle_pct = 13;
                rx_idle_pct = 80;
            end else if (ph < 4) begin
                tx_idle_pct = 80;
                rx_idle_pct = 13;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // The first phase keeps the reset ids.
            if (ph != 0) begin
                case (ph)
                    1: ids = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE};
                    2: ids = '{16'h0101, 16'h0101, 16'h0202, 16'h0101};
                    4: ids = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
                    default: foreach (ids[k]) ids[k] = 16'($urandom);
                endcase
                for (int k = 0; k < NUM_IDS; k++) apb_access(1'b1, 2'(k), ids[k]);
            end
            for (int k = 0; k < NUM_IDS; k++) apb_access(1'b0, 2'(k), 16'h0000);
            phase_no = ph;
            start = sent_count;
            // Messages of 255 and 256 bytes sit on either side of the size limit.
            if (ph == 4) begin
                send_message(251);
                send_message(252);
            end
            while (sent_count - start < PHASE_ITEMS) send_message(-1);
        end

        drain_results(10);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
